// ----- src/brfs_pkg.sv -----
`timescale 1ns / 1ps

package brfs_pkg;

	localparam int DEPTH         = 4096;
	localparam int ADDR_W        = $clog2(DEPTH);
	localparam int FILL_W        = ADDR_W + 1;
	localparam int MAX_BURST_DEF = 16;

	typedef enum logic [2:0] {
		KIND_WRITE = 3'd0,
		KIND_READ  = 3'd1,
		KIND_PEEK  = 3'd2,
		KIND_SKIP  = 3'd3,
		KIND_FIND  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVAL    = 2'd1,
		ST_OVER     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BURST_RD,
		S_BURST_OUT,
		S_FIND
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [12:0] count;
		logic [11:0] offset;
	} req_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        byte_valid;
		status_t     status;
		logic [11:0] found_index;
		logic [12:0] fill_level;
		logic        last;
	} rsp_t;

endpackage

// ----- src/byte_ring_fifo_with_search_top.sv -----
`timescale 1ns / 1ps

// Byte ring FIFO with search.
// Request channel (req_valid/req_stall/req) carries one command: write byte,
// read burst, peek burst, skip, or find. Response channel
// (rsp_valid/rsp_stall/rsp) returns one or more responses per request; the
// final one has last set, and each carries the fill level after the command.
// Write, skip, invalid kinds and empty bursts: the response is registered
// from the request, and the next request can be taken while that response
// is presented, so writes run at one per cycle while rsp_stall stays low.
// Read/peek: each delivered byte takes a memory read, then the response
// register, up to MAX_BURST bytes; the next request waits for the last byte.
// Find: the scan reads one storage byte per cycle from the offset and
// compares it to the key; it stops at the first match, or at the fill level
// when nothing matches, and answers without reading when the offset is at
// or beyond the fill level.
// Reset clears head, fill and chunk tracking; storage is not cleared.
// While rsp_stall holds the response register full, req_stall stays high;
// a burst fetches its next byte and then waits for the register to free.
module byte_ring_fifo_with_search_top #(
	parameter int MAX_BURST = brfs_pkg::MAX_BURST_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  brfs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output brfs_pkg::rsp_t rsp
);
	import brfs_pkg::*;

	localparam int BW = $clog2(MAX_BURST + 1);

	logic [7:0] mem [DEPTH];

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   head_q, head_d;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic [FILL_W-1:0]   chunk_left_q, chunk_left_d;
	logic                chunk_drop_q, chunk_drop_d;
	logic [ADDR_W-1:0]   base_q, base_d;
	logic [BW-1:0]       burst_n_q, burst_n_d;
	logic [BW-1:0]       burst_i_q, burst_i_d;
	logic [7:0]          key_q, key_d;
	logic [FILL_W-1:0]   scan_q, scan_d;
	logic                cmp_v_q, cmp_v_d;
	logic [ADDR_W-1:0]   cmp_idx_q, cmp_idx_d;
	logic [7:0]          rdata_q;
	rsp_t                rsp_q, rsp_d;
	logic                rsp_valid_q, rsp_valid_d;

	logic                out_free;
	logic                accept;
	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;

	logic                wr_start, wr_drop, wr_store;
	logic [FILL_W-1:0]   wr_left;
	status_t             wr_status;
	logic [FILL_W-1:0]   rd_m;
	logic                burst_last;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		wr_start  = (chunk_left_q == '0) || (req.count != chunk_left_q);
		wr_drop   = chunk_drop_q;
		wr_left   = req.count - FILL_W'(1);
		wr_store  = 1'b0;
		wr_status = ST_OK;
		if (wr_start) begin
			wr_drop = ({1'b0, fill_q} + {1'b0, req.count}) > (FILL_W + 1)'(DEPTH);
		end
		if (wr_start && req.count == '0) begin
			wr_drop   = 1'b0;
			wr_left   = '0;
			wr_status = ST_INVAL;
		end else if (wr_drop || fill_q >= FILL_W'(DEPTH)) begin
			wr_status = ST_OVER;
			if (wr_left == '0) begin
				wr_drop = 1'b0;
			end
		end else begin
			wr_store = 1'b1;
		end
	end

	always_comb begin
		rd_m = (req.count < fill_q) ? req.count : fill_q;
		if (rd_m > FILL_W'(MAX_BURST)) begin
			rd_m = FILL_W'(MAX_BURST);
		end
	end

	assign burst_last = (burst_i_q == burst_n_q - BW'(1));

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		fill_d       = fill_q;
		chunk_left_d = chunk_left_q;
		chunk_drop_d = chunk_drop_q;
		base_d       = base_q;
		burst_n_d    = burst_n_q;
		burst_i_d    = burst_i_q;
		key_d        = key_q;
		scan_d       = scan_q;
		cmp_v_d      = cmp_v_q;
		cmp_idx_d    = cmp_idx_q;
		rsp_d        = rsp_q;
		rsp_valid_d  = rsp_valid_q && rsp_stall;
		mem_we       = 1'b0;
		mem_waddr    = head_q + fill_q[ADDR_W-1:0];
		mem_re       = 1'b0;
		mem_raddr    = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_d.byte_out    = '0;
					rsp_d.byte_valid  = 1'b0;
					rsp_d.status      = ST_OK;
					rsp_d.found_index = '0;
					rsp_d.last        = 1'b1;
					rsp_valid_d       = 1'b1;
					case (req.kind)
						KIND_WRITE: begin
							chunk_left_d = wr_left;
							chunk_drop_d = wr_drop;
							rsp_d.status = wr_status;
							if (wr_store) begin
								mem_we = 1'b1;
								fill_d = fill_q + FILL_W'(1);
							end
						end
						KIND_READ, KIND_PEEK: begin
							if (req.kind == KIND_READ) begin
								head_d = head_q + rd_m[ADDR_W-1:0];
								fill_d = fill_q - rd_m;
							end
							if (rd_m != '0) begin
								rsp_valid_d = 1'b0;
								base_d      = head_q;
								burst_n_d   = rd_m[BW-1:0];
								burst_i_d   = '0;
								state_d     = S_BURST_RD;
							end
						end
						KIND_SKIP: begin
							if (req.count > fill_q) begin
								rsp_d.status = ST_INVAL;
							end else begin
								head_d = head_q + req.count[ADDR_W-1:0];
								fill_d = fill_q - req.count;
							end
						end
						KIND_FIND: begin
							rsp_valid_d = 1'b0;
							key_d       = req.data_byte;
							scan_d      = {1'b0, req.offset};
							cmp_v_d     = 1'b0;
							state_d     = S_FIND;
						end
						default: begin
							rsp_d.status = ST_INVAL;
						end
					endcase
					rsp_d.fill_level = fill_d;
				end
			end
			S_BURST_RD: begin
				mem_re    = 1'b1;
				mem_raddr = base_q + ADDR_W'(burst_i_q);
				state_d   = S_BURST_OUT;
			end
			S_BURST_OUT: begin
				if (out_free) begin
					rsp_valid_d       = 1'b1;
					rsp_d.byte_out    = rdata_q;
					rsp_d.byte_valid  = 1'b1;
					rsp_d.status      = ST_OK;
					rsp_d.found_index = '0;
					rsp_d.fill_level  = fill_q;
					rsp_d.last        = burst_last;
					burst_i_d         = burst_i_q + BW'(1);
					state_d           = burst_last ? S_IDLE : S_BURST_RD;
				end
			end
			S_FIND: begin
				rsp_d.byte_out   = '0;
				rsp_d.byte_valid = 1'b0;
				rsp_d.fill_level = fill_q;
				rsp_d.last       = 1'b1;
				if (cmp_v_q && rdata_q == key_q) begin
					if (out_free) begin
						rsp_valid_d       = 1'b1;
						rsp_d.status      = ST_OK;
						rsp_d.found_index = cmp_idx_q;
						cmp_v_d           = 1'b0;
						state_d           = S_IDLE;
					end
				end else if (scan_q < fill_q) begin
					mem_re    = 1'b1;
					mem_raddr = head_q + scan_q[ADDR_W-1:0];
					cmp_v_d   = 1'b1;
					cmp_idx_d = scan_q[ADDR_W-1:0];
					scan_d    = scan_q + FILL_W'(1);
				end else begin
					cmp_v_d = 1'b0;
					if (!cmp_v_q && out_free) begin
						rsp_valid_d       = 1'b1;
						rsp_d.status      = ST_NOTFOUND;
						rsp_d.found_index = '0;
						state_d           = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// storage RAM, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= req.data_byte;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			fill_q       <= '0;
			chunk_left_q <= '0;
			chunk_drop_q <= 1'b0;
			cmp_v_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			fill_q       <= fill_d;
			chunk_left_q <= chunk_left_d;
			chunk_drop_q <= chunk_drop_d;
			cmp_v_q      <= cmp_v_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q    <= base_d;
		burst_n_q <= burst_n_d;
		burst_i_q <= burst_i_d;
		key_q     <= key_d;
		scan_q    <= scan_d;
		cmp_idx_q <= cmp_idx_d;
		rsp_q     <= rsp_d;
	end

endmodule

// ----- src/brfs_chk.sv -----
`timescale 1ns / 1ps

module brfs_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input brfs_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input brfs_pkg::rsp_t rsp
);
	import brfs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.fill_level <= 13'(DEPTH))
		else $error("fill level beyond capacity");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.byte_valid |-> rsp.status == ST_OK && rsp.found_index == '0)
		else $error("delivered byte with bad status or index");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.byte_valid |-> rsp.byte_out == '0 && rsp.last)
		else $error("non-byte response not final or has data");

	a_err_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.found_index == '0)
		else $error("error response carries an index");

endmodule

bind byte_ring_fifo_with_search_top brfs_chk u_brfs_chk (.*);

// ----- test/byte_ring_fifo_with_search_top_tb.sv -----
`timescale 1ns / 1ps

module byte_ring_fifo_with_search_top_tb;
	import brfs_pkg::*;

	localparam int BURST_MAX = MAX_BURST_DEF;
	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
	localparam int MAX_PRINTS = 40;
	localparam int FILL_BAND = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	byte_ring_fifo_with_search_top #(.MAX_BURST(BURST_MAX)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// shadow of the ring
	logic [7:0] ring_mem [DEPTH];
	int ring_head = 0;
	int ring_fill = 0;
	int chunk_remaining = 0;
	bit chunk_refused = 1'b0;

	rsp_t expected_rsp [$];
	req_t pending_req [$];

	int n_sent = 0;
	int n_accepted = 0;
	int n_rsp = 0;
	int n_errors = 0;
	int n_random = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_len = 0;
	int stall_left = 0;
	int gen_fill = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic rsp_t make_rsp(input logic [7:0] b, input logic v, input status_t st,
			input int idx, input logic is_last);
		rsp_t r;
		r.byte_out = b;
		r.byte_valid = v;
		r.status = st;
		r.found_index = 12'(idx);
		r.fill_level = 13'(ring_fill);
		r.last = is_last;
		return r;
	endfunction

	task automatic predict_request(input req_t r);
		int n;
		int idx;
		bit starts;
		status_t st;
		logic [7:0] burst [BURST_MAX];
		case (r.kind)
			KIND_WRITE: begin
				starts = (chunk_remaining == 0) || (int'(r.count) != chunk_remaining);
				st = ST_OK;
				if (starts) begin
					chunk_refused = 1'b0;
					if (ring_fill + int'(r.count) > DEPTH)
						chunk_refused = 1'b1;
				end
				if (starts && r.count == 0) begin
					chunk_remaining = 0;
					st = ST_INVAL;
				end else begin
					chunk_remaining = int'(r.count) - 1;
					if (chunk_refused || ring_fill >= DEPTH) begin
						if (chunk_remaining == 0)
							chunk_refused = 1'b0;
						st = ST_OVER;
					end else begin
						ring_mem[(ring_head + ring_fill) % DEPTH] = r.data_byte;
						ring_fill++;
					end
				end
				expected_rsp.push_back(make_rsp(8'h00, 1'b0, st, 0, 1'b1));
			end
			KIND_READ, KIND_PEEK: begin
				n = int'(r.count);
				if (n > ring_fill)
					n = ring_fill;
				if (n > BURST_MAX)
					n = BURST_MAX;
				for (int i = 0; i < n; i++)
					burst[i] = ring_mem[(ring_head + i) % DEPTH];
				if (r.kind == KIND_READ) begin
					ring_head = (ring_head + n) % DEPTH;
					ring_fill -= n;
				end
				if (n == 0)
					expected_rsp.push_back(make_rsp(8'h00, 1'b0, ST_OK, 0, 1'b1));
				for (int i = 0; i < n; i++)
					expected_rsp.push_back(make_rsp(burst[i], 1'b1, ST_OK, 0, i == n - 1));
			end
			KIND_SKIP: begin
				if (int'(r.count) > ring_fill) begin
					expected_rsp.push_back(make_rsp(8'h00, 1'b0, ST_INVAL, 0, 1'b1));
				end else begin
					ring_head = (ring_head + int'(r.count)) % DEPTH;
					ring_fill -= int'(r.count);
					expected_rsp.push_back(make_rsp(8'h00, 1'b0, ST_OK, 0, 1'b1));
				end
			end
			KIND_FIND: begin
				idx = -1;
				for (int i = int'(r.offset); i < ring_fill && idx < 0; i++)
					if (ring_mem[(ring_head + i) % DEPTH] == r.data_byte)
						idx = i;
				if (idx < 0)
					expected_rsp.push_back(make_rsp(8'h00, 1'b0, ST_NOTFOUND, 0, 1'b1));
				else
					expected_rsp.push_back(make_rsp(8'h00, 1'b0, ST_OK, idx, 1'b1));
			end
			default: begin
				expected_rsp.push_back(make_rsp(8'h00, 1'b0, ST_INVAL, 0, 1'b1));
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_response(input rsp_t got, input rsp_t want);
		if (got.byte_out !== want.byte_out)
			report_mismatch("byte_out", 32'(got.byte_out), 32'(want.byte_out));
		if (got.byte_valid !== want.byte_valid)
			report_mismatch("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.found_index !== want.found_index)
			report_mismatch("found_index", 32'(got.found_index), 32'(want.found_index));
		if (got.fill_level !== want.fill_level)
			report_mismatch("fill_level", 32'(got.fill_level), 32'(want.fill_level));
		if (got.last !== want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	// monitor: request acceptance feeds the shadow ring, responses are checked in order
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			n_accepted++;
			predict_request(req);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_rsp++;
			if (expected_rsp.size() == 0)
				report_mismatch("response with none pending", 32'(rsp), 32'(0));
			else
				check_response(rsp, expected_rsp.pop_front());
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (n_accepted == n_sent) begin
			if (pending_req.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
				n_sent++;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response stall, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_len != 0) begin
			stall_left = hold_len;
			hold_len = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || n_sent != n_accepted || expected_rsp.size() != 0);
	endtask

	task automatic push_req(input logic [2:0] kind, input int data, input int count,
			input int offset);
		req_t r;
		r.kind = kind;
		r.data_byte = 8'(data);
		r.count = 13'(count);
		r.offset = 12'(offset);
		pending_req.push_back(r);
	endtask

	// small alphabet half the time so that searches hit
	function automatic int pick_byte();
		return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
	endfunction

	task automatic push_chunk(input int len, input int declared);
		for (int k = 0; k < len; k++)
			push_req(KIND_WRITE, pick_byte(), declared - k, 0);
	endtask

	task automatic random_batch(input int n_items);
		int target;
		int op;
		int len;
		int cnt;
		int n;
		target = n_random + n_items;
		gen_fill = ring_fill;
		while (n_random < target) begin
			op = $urandom_range(0, 99);
			if (op >= 56 && gen_fill > FILL_BAND)
				op = $urandom_range(0, 17);
			if (op < 26) begin
				cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 20);
				push_req(op < 18 ? KIND_READ : KIND_PEEK, pick_byte(), cnt, $urandom_range(0, 4095));
				n = cnt < gen_fill ? cnt : gen_fill;
				if (n > BURST_MAX)
					n = BURST_MAX;
				if (op < 18)
					gen_fill -= n;
				n_random++;
			end else if (op < 34) begin
				cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
					: $urandom_range(0, gen_fill + 2);
				push_req(KIND_SKIP, pick_byte(), cnt, 0);
				if (cnt <= gen_fill)
					gen_fill -= cnt;
				n_random++;
			end else if (op < 48) begin
				push_req(KIND_FIND, pick_byte(), $urandom_range(0, 8191),
					($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
					: $urandom_range(0, gen_fill + 2));
				n_random++;
			end else if (op < 52) begin
				push_req(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), pick_byte(),
					$urandom_range(0, 8191), $urandom_range(0, 4095));
				n_random++;
			end else if (op < 56) begin
				// truncated or oversized chunk
				cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 12);
				len = $urandom_range(1, 4);
				push_chunk(len, cnt);
				if (cnt >= len && gen_fill + cnt <= DEPTH)
					gen_fill += len;
				n_random += len;
			end else begin
				len = $urandom_range(1, 12);
				push_chunk(len, len);
				if (gen_fill + len <= DEPTH)
					gen_fill += len;
				n_random += len;
			end
		end
		wait_drained();
	endtask

	initial begin
		snd_idle_pct = 7;
		rcv_idle_pct = 56;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_req(KIND_FIND, 8'h00, 0, 0);
		push_req(KIND_READ, 0, 5, 0);
		push_req(KIND_PEEK, 0, 0, 0);
		push_req(KIND_SKIP, 0, 0, 0);
		push_req(KIND_SKIP, 0, 1, 0);
		push_req(KIND_WRITE, 8'h44, 0, 0);
		push_req(KIND_WRITE, 8'h00, 3, 0);
		push_req(KIND_WRITE, 8'hFF, 2, 0);
		push_req(KIND_WRITE, 8'hA5, 1, 0);
		push_req(KIND_WRITE, 8'h11, DEPTH, 0);
		push_req(KIND_WRITE, 8'h22, DEPTH - 1, 0);
		push_req(KIND_WRITE, 8'h33, 8191, 0);
		push_req(KIND_WRITE, 8'h5A, 1, 0);
		push_req(KIND_PEEK, 0, 8191, 0);
		push_req(KIND_FIND, 8'hA5, 0, 0);
		push_req(KIND_FIND, 8'hFF, 0, 2);
		push_req(KIND_FIND, 8'h5A, 0, 4095);
		push_req(KIND_FIND, 8'h00, 0, 0);
		push_req(KIND_READ, 0, 2, 0);
		push_req(KIND_SKIP, 0, DEPTH, 0);
		push_req(KIND_READ, 0, 8191, 0);
		push_req(KIND_UNUSED_LO, 8'hFF, 8191, 4095);
		push_req(KIND_UNUSED_HI, 0, 0, 0);
		push_req(KIND_UNUSED_MID, 0, 0, 0);
		push_req(KIND_SKIP, 0, 8191, 0);
		wait_drained();

		// receiver holds off while requests keep coming
		@(posedge clk);
		hold_len = 300;
		push_chunk(24, 24);
		push_req(KIND_PEEK, 0, BURST_MAX, 0);
		push_req(KIND_FIND, 8'h07, 0, 0);
		push_req(KIND_READ, 0, BURST_MAX, 0);
		wait_drained();

		random_batch(24);
		random_batch(24);

		snd_idle_pct = 56;
		rcv_idle_pct = 7;
		random_batch(24);
		random_batch(24);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		random_batch(20);

		wait_drained();
		repeat (40) @(negedge clk);
		$display("%0d requests (%0d random) gave %0d responses, %0d mismatches",
			n_sent, n_random, n_rsp, n_errors);
		$display("edge cases, a long receiver hold-off, bursts, searches, skips and refused chunks");
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/brfs_pkg.sv
src/byte_ring_fifo_with_search_top.sv
src/brfs_chk.sv
test/byte_ring_fifo_with_search_top_tb.sv
